// ----- rtl/julian_date_to_gregorian_top_defines.svh -----
// ---------------------------------------------------------------------------
// julian date to gregorian: assertion macros
// concurrent check wrappers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef JULIAN_DATE_TO_GREGORIAN_TOP_DEFINES_SVH
`define JULIAN_DATE_TO_GREGORIAN_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define JDG_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("jdg check failed");
// next-cycle implication
`define JDG_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("jdg check failed");
`else
`define JDG_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define JDG_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ----- rtl/jdg_pkg.sv -----
// ---------------------------------------------------------------------------
// jdg_pkg
// types, constants and tables shared by the julian date converter
// ---------------------------------------------------------------------------
package jdg_pkg;

    // pipeline depths
    localparam int DATE_STAGES = 10;
    localparam int TIME_STAGES = 7;
    localparam int TIME_PAD    = DATE_STAGES - TIME_STAGES;

    typedef struct packed {
        logic [23:0] julian_day;
        logic [26:0] ms_since_noon;
    } jdg_req_t;

    typedef struct packed {
        logic signed [16:0] year;
        logic [3:0]         month;
        logic [4:0]         day_of_month;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [9:0]         millisecond;
    } jdg_res_t;

    typedef struct packed {
        logic signed [16:0] year;
        logic [3:0]         month;
        logic [4:0]         day_of_month;
    } jdg_date_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [9:0] millisecond;
    } jdg_tod_t;

    // time of day
    localparam logic [26:0] MS_LAST      = 27'd86399999;
    localparam logic [26:0] MS_DAY       = 27'd86400000;
    localparam logic [26:0] MS_HALF_DAY  = 27'd43200000;
    localparam logic [26:0] MS_PER_SEC   = 27'd1000;
    localparam logic [17:0] SEC_RECIP    = 18'd134217;   // floor(2^27 / 1000)
    localparam logic [11:0] MIN_RECIP    = 12'd2184;     // floor(2^17 / 60)
    localparam logic [5:0]  HOUR_RECIP   = 6'd34;        // floor(2^11 / 60)

    // calendar
    localparam logic [24:0] GREG_START   = 25'd2299161;
    localparam logic [26:0] ALPHA_BIAS   = 27'd7468865;
    localparam logic [26:0] ALPHA_DIV    = 27'd146097;
    localparam logic [8:0]  ALPHA_RECIP  = 9'd459;       // floor(2^26 / 146097)
    localparam logic [24:0] B_OFS        = 25'd1524;
    localparam logic [28:0] C_BIAS       = 29'd2442;
    localparam logic [28:0] C_DIV        = 29'd7305;
    localparam logic [16:0] C_RECIP      = 17'd73493;    // floor(2^29 / 7305)
    localparam logic [26:0] D_MUL        = 27'd1461;
    localparam logic [14:0] E_RECIP      = 15'd17133;    // floor(2^19 * 10000 / 306001)
    localparam logic [22:0] E_SCALE      = 23'd10000;
    localparam logic [22:0] E_DIV        = 23'd306001;
    localparam logic signed [16:0] YEAR_OFS_EARLY = 17'sd4715;
    localparam logic signed [16:0] YEAR_OFS_LATE  = 17'sd4716;

    // floor(30.6001 * e)
    function automatic logic [8:0] month_offset(input logic [3:0] e);
        logic [8:0] ofs;
        case (e)
            4'd1:    ofs = 9'd30;
            4'd2:    ofs = 9'd61;
            4'd3:    ofs = 9'd91;
            4'd4:    ofs = 9'd122;
            4'd5:    ofs = 9'd153;
            4'd6:    ofs = 9'd183;
            4'd7:    ofs = 9'd214;
            4'd8:    ofs = 9'd244;
            4'd9:    ofs = 9'd275;
            4'd10:   ofs = 9'd306;
            4'd11:   ofs = 9'd336;
            4'd12:   ofs = 9'd367;
            4'd13:   ofs = 9'd397;
            4'd14:   ofs = 9'd428;
            4'd15:   ofs = 9'd459;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

endpackage

// ----- rtl/jdg_time.sv -----
// ---------------------------------------------------------------------------
// jdg_time
// seven-stage split of milliseconds past noon into civil time of day
// ---------------------------------------------------------------------------
module jdg_time (
    input  logic             clk,
    input  jdg_pkg::jdg_req_t request,
    output jdg_pkg::jdg_tod_t tod
);
    import jdg_pkg::*;

    logic [26:0] ms1_reg, ms1_next;
    logic [26:0] ms2_reg;
    logic [16:0] s0_reg, s0_next;
    logic [44:0] s_prod;
    logic [26:0] s_back, s_rem;
    logic        s_inc;
    logic [16:0] secs3_reg, secs3_next, secs4_reg;
    logic [9:0]  msr3_reg, msr3_next, msr4_reg, msr5_reg, msr6_reg;
    logic [28:0] m_prod;
    logic [10:0] m0_reg, m0_next;
    logic [16:0] m_back, m_rem;
    logic        m_inc;
    logic [10:0] mins5_reg, mins5_next, mins6_reg;
    logic [5:0]  sec5_reg, sec5_next, sec6_reg;
    logic [16:0] h_prod;
    logic [4:0]  h0_reg, h0_next;
    logic [10:0] h_back, h_rem;
    logic        h_inc;
    logic [4:0]  hours;
    jdg_tod_t    tod_reg, tod_next;

    always_comb
    begin
        ms1_next   = (request.ms_since_noon >= MS_DAY) ? MS_LAST : request.ms_since_noon;

        // seconds estimate, low by at most one
        s_prod     = 45'(ms1_reg) * 45'(SEC_RECIP);
        s0_next    = s_prod[43:27];

        s_back     = 27'(s0_reg) * MS_PER_SEC;
        s_rem      = ms2_reg - s_back;
        s_inc      = s_rem >= MS_PER_SEC;
        secs3_next = s0_reg + 17'(s_inc);
        msr3_next  = s_inc ? 10'(s_rem - MS_PER_SEC) : s_rem[9:0];

        m_prod     = 29'(secs3_reg) * 29'(MIN_RECIP);
        m0_next    = m_prod[27:17];

        m_back     = 17'(m0_reg) * 17'd60;
        m_rem      = secs4_reg - m_back;
        m_inc      = m_rem >= 17'd60;
        mins5_next = m0_reg + 11'(m_inc);
        sec5_next  = m_inc ? 6'(m_rem - 17'd60) : m_rem[5:0];

        h_prod     = 17'(mins5_reg) * 17'(HOUR_RECIP);
        h0_next    = h_prod[15:11];

        h_back     = 11'(h0_reg) * 11'd60;
        h_rem      = mins6_reg - h_back;
        h_inc      = h_rem >= 11'd60;
        hours      = h0_reg + 5'(h_inc);
        // counted from noon: wrap into the next civil day
        tod_next.hour        = (hours >= 5'd12) ? hours - 5'd12 : hours + 5'd12;
        tod_next.minute      = h_inc ? 6'(h_rem - 11'd60) : h_rem[5:0];
        tod_next.second      = sec6_reg;
        tod_next.millisecond = msr6_reg;
    end

    always_ff @(posedge clk)
    begin
        ms1_reg   <= ms1_next;
        ms2_reg   <= ms1_reg;
        s0_reg    <= s0_next;
        secs3_reg <= secs3_next;
        msr3_reg  <= msr3_next;
        secs4_reg <= secs3_reg;
        m0_reg    <= m0_next;
        msr4_reg  <= msr3_reg;
        mins5_reg <= mins5_next;
        sec5_reg  <= sec5_next;
        msr5_reg  <= msr4_reg;
        h0_reg    <= h0_next;
        mins6_reg <= mins5_reg;
        sec6_reg  <= sec5_reg;
        msr6_reg  <= msr5_reg;
        tod_reg   <= tod_next;
    end

    assign tod = tod_reg;

endmodule

// ----- rtl/jdg_date.sv -----
// ---------------------------------------------------------------------------
// jdg_date
// ten-stage julian day number to calendar date, three constant divides
// ---------------------------------------------------------------------------
module jdg_date (
    input  logic              clk,
    input  jdg_pkg::jdg_req_t request,
    output jdg_pkg::jdg_date_t date
);
    import jdg_pkg::*;

    logic        next_day;
    logic [24:0] z1_reg, z1_next, z2_reg, z3_reg;
    logic        greg1_next, greg1_reg, greg2_reg, greg3_reg;
    logic [26:0] na_full;
    logic [25:0] na1_reg, na1_next, na2_reg;
    logic [34:0] a_prod;
    logic [8:0]  q0_reg, q0_next;
    logic [26:0] a_back, a_rem;
    logic [8:0]  alpha3_reg, alpha3_next;
    logic [24:0] a_val, b_val;
    logic [28:0] nc_full;
    logic [24:0] b4_reg, b5_reg, b6_reg;
    logic [28:0] nc4_reg, nc5_reg;
    logic [45:0] c_prod;
    logic [15:0] c0_reg, c0_next;
    logic [28:0] c_back, c_rem;
    logic [15:0] c6_reg, c6_next, c7_reg, c8_reg, c9_reg;
    logic [26:0] d_full;
    logic [24:0] x_full;
    logic [8:0]  x7_reg, x7_next, x8_reg, x9_reg;
    logic [23:0] e_prod;
    logic [4:0]  e0_reg, e0_next;
    logic [22:0] e_lhs, e_rhs;
    logic [4:0]  e9_reg, e9_next;
    logic [4:0]  month_full;
    logic [8:0]  day_full;
    jdg_date_t   date_reg, date_next;

    always_comb
    begin
        // hour from noon reaches midnight: date of the following day
        next_day   = request.ms_since_noon >= MS_HALF_DAY;
        z1_next    = {1'b0, request.julian_day} + 25'(next_day);
        greg1_next = z1_next >= GREG_START;
        na_full    = {z1_next, 2'b00} - ALPHA_BIAS;
        na1_next   = na_full[25:0];

        a_prod     = 35'(na1_reg) * 35'(ALPHA_RECIP);
        q0_next    = a_prod[34:26];

        a_back      = 27'(q0_reg) * ALPHA_DIV;
        a_rem       = {1'b0, na2_reg} - a_back;
        alpha3_next = q0_reg + 9'(a_rem >= ALPHA_DIV);

        a_val   = greg3_reg ? z3_reg + 25'd1 + 25'(alpha3_reg) - 25'(alpha3_reg >> 2) : z3_reg;
        b_val   = a_val + B_OFS;
        nc_full = 29'(b_val) * 29'd20 - C_BIAS;

        c_prod  = 46'(nc4_reg) * 46'(C_RECIP);
        c0_next = c_prod[44:29];

        c_back  = 29'(c0_reg) * C_DIV;
        c_rem   = nc5_reg - c_back;
        c6_next = c0_reg + 16'(c_rem >= C_DIV);

        d_full  = 27'(c6_reg) * D_MUL;
        x_full  = b6_reg - d_full[26:2];
        x7_next = x_full[8:0];

        e_prod  = 24'(x7_reg) * 24'(E_RECIP);
        e0_next = e_prod[23:19];

        e_lhs   = 23'(x8_reg) * E_SCALE;
        e_rhs   = 23'(e0_reg + 5'd1) * E_DIV;
        e9_next = e0_reg + 5'(e_lhs >= e_rhs);

        month_full = (e9_reg <= 5'd13) ? e9_reg - 5'd1 : e9_reg - 5'd13;
        day_full   = x9_reg - month_offset(e9_reg[3:0]);
        date_next.month        = month_full[3:0];
        date_next.day_of_month = day_full[4:0];
        date_next.year         = $signed({1'b0, c9_reg})
                               - ((month_full <= 5'd2) ? YEAR_OFS_EARLY : YEAR_OFS_LATE);
    end

    always_ff @(posedge clk)
    begin
        z1_reg     <= z1_next;
        greg1_reg  <= greg1_next;
        na1_reg    <= na1_next;
        z2_reg     <= z1_reg;
        greg2_reg  <= greg1_reg;
        na2_reg    <= na1_reg;
        q0_reg     <= q0_next;
        z3_reg     <= z2_reg;
        greg3_reg  <= greg2_reg;
        alpha3_reg <= alpha3_next;
        b4_reg     <= b_val;
        nc4_reg    <= nc_full;
        b5_reg     <= b4_reg;
        nc5_reg    <= nc4_reg;
        c0_reg     <= c0_next;
        b6_reg     <= b5_reg;
        c6_reg     <= c6_next;
        x7_reg     <= x7_next;
        c7_reg     <= c6_reg;
        x8_reg     <= x7_reg;
        c8_reg     <= c7_reg;
        e0_reg     <= e0_next;
        x9_reg     <= x8_reg;
        c9_reg     <= c8_reg;
        e9_reg     <= e9_next;
        date_reg   <= date_next;
    end

    assign date = date_reg;

endmodule

// ----- rtl/julian_date_to_gregorian_top.sv -----
// ---------------------------------------------------------------------------
// julian_date_to_gregorian_top
// julian day number and ms past noon to calendar date and time of day
// ---------------------------------------------------------------------------
//  channel   strobe        payload    direction
//  request   start/busy    request    in
//  result    done          result     out
//
//  one item per cycle; results leave in the order their items are taken
//  latency is set by the date path: three constant divides, each a reciprocal
//  multiply stage followed by a correction stage
//  busy stays low: the pipeline never stalls, results are shown for one cycle
//  reset clears only the valid bits; payload registers are not reset
// ---------------------------------------------------------------------------
`include "julian_date_to_gregorian_top_defines.svh"

module julian_date_to_gregorian_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  jdg_pkg::jdg_req_t request,
    output logic              done,
    output jdg_pkg::jdg_res_t result
);
    import jdg_pkg::*;

    logic [DATE_STAGES-1:0] valid_reg, valid_next;
    jdg_date_t              date;
    jdg_tod_t               tod;
    jdg_tod_t               tod_pad_reg [TIME_PAD];

    jdg_date u_date (
        .clk     (clk),
        .request (request),
        .date    (date)
    );

    jdg_time u_time (
        .clk     (clk),
        .request (request),
        .tod     (tod)
    );

    assign busy = 1'b0;

    always_comb
    begin
        valid_next = {valid_reg[DATE_STAGES-2:0], start && !busy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // line the time of day up with the longer date path
    always_ff @(posedge clk)
    begin
        tod_pad_reg[0] <= tod;
        for (int i = 1; i < TIME_PAD; i++)
        begin
            tod_pad_reg[i] <= tod_pad_reg[i-1];
        end
    end

    assign done                = valid_reg[DATE_STAGES-1];
    assign result.year         = date.year;
    assign result.month        = date.month;
    assign result.day_of_month = date.day_of_month;
    assign result.hour         = tod_pad_reg[TIME_PAD-1].hour;
    assign result.minute       = tod_pad_reg[TIME_PAD-1].minute;
    assign result.second       = tod_pad_reg[TIME_PAD-1].second;
    assign result.millisecond  = tod_pad_reg[TIME_PAD-1].millisecond;

    `JDG_ASSERT_IMPL(a_month_range, clk, rst_n, done, result.month >= 4'd1 && result.month <= 4'd12)
    `JDG_ASSERT_IMPL(a_day_range, clk, rst_n, done, result.day_of_month >= 5'd1)
    `JDG_ASSERT_IMPL(a_hm_range, clk, rst_n, done, result.hour <= 5'd23 && result.minute <= 6'd59)
    `JDG_ASSERT_IMPL(a_sms_range, clk, rst_n, done, result.second <= 6'd59 && result.millisecond <= 10'd999)
    `JDG_ASSERT_NEXT(a_no_drop, clk, rst_n, valid_reg[DATE_STAGES-2], done)

endmodule
